FILE: src/ctc_pkg.sv
package ctc_pkg;

   // Number of reserved-word match slots; only the first WORD_COUNT are defined.
   localparam int KEYWORD_COUNT = 16;
   localparam int WORD_COUNT = 16;
   localparam int WORD_MAX = 8;
   localparam logic [3:0] POS_MAX = 4'd9;

   // output queue slots; count and entry indexes are 3 bits wide
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_RESERVED = 3'd0,
      KIND_OPERATOR = 3'd1,
      KIND_INTEGER  = 3'd2,
      KIND_FLOAT    = 3'd3,
      KIND_VARIABLE = 3'd4,
      KIND_LINE_END = 3'd5,
      KIND_ST_ERROR = 3'd6,
      KIND_ST_OK    = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
   } rsl_type;

   // Results caused by one accepted word, in order: res0 first.
   typedef struct packed {
      logic [1:0] num;
      rsl_type    res0;
      rsl_type    res1;
   } push_type;

   localparam logic [7:0] Z = 8'h00;

   localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAX] = '{
      '{"c", "o", "n", "s", "t", Z,   Z,   Z},
      '{"i", "n", "t", Z,   Z,   Z,   Z,   Z},
      '{"f", "l", "o", "a", "t", Z,   Z,   Z},
      '{"d", "o", "u", "b", "l", "e", Z,   Z},
      '{"l", "o", "n", "g", Z,   Z,   Z,   Z},
      '{"s", "t", "a", "t", "i", "c", Z,   Z},
      '{"v", "o", "i", "d", Z,   Z,   Z,   Z},
      '{"c", "h", "a", "r", Z,   Z,   Z,   Z},
      '{"e", "x", "t", "e", "r", "n", Z,   Z},
      '{"r", "e", "t", "u", "r", "n", Z,   Z},
      '{"b", "r", "e", "a", "k", Z,   Z,   Z},
      '{"e", "n", "u", "m", Z,   Z,   Z,   Z},
      '{"s", "t", "r", "u", "c", "t", Z,   Z},
      '{"t", "y", "p", "e", "d", "e", "f", Z},
      '{"u", "n", "i", "o", "n", Z,   Z,   Z},
      '{"g", "o", "t", "o", Z,   Z,   Z,   Z}
   };

   localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
      4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
      4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
   };

endpackage

FILE: src/c_subset_token_classifier_core.sv
// Token classifier for a small C subset. One source byte per word on req_;
// req_end_of_text closes the text, emits a status (7 ok, 6 error) and clears
// all state. Each word passes through the match logic and yields zero
// to two result words on rsp_, the final one of each input word flagged by
// rsp_last. A four-word output queue sets the rate: req_ready stays high while
// at least two queue slots are free, so one byte per cycle is sustained while
// rsp_ready is high; results are registered in the queue.
module c_subset_token_classifier_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_character,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_last
);

   ctc_pkg::push_type push;
   ctc_pkg::rsl_type  out_word;
   logic              accept;

   assign accept = req_valid && req_ready;

   ctc_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .character   (req_character),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   ctc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_token_kind = 3'(out_word.kind);
   assign rsp_last       = out_word.last;

endmodule

FILE: src/ctc_classifier.sv
module ctc_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        character,
   input  logic              end_of_text,
   output ctc_pkg::push_type push
);

   localparam int KC = ctc_pkg::KEYWORD_COUNT;

   logic          open_ff, open_in;
   logic [3:0]    pos_ff, pos_in;
   logic [KC-1:0] cand_ff, cand_in;
   logic [7:0]    opf_ff, opf_in;
   logic          num_ff, num_in;
   logic [1:0]    dot_ff, dot_in;
   logic          ident_ff, ident_in;
   logic          err_ff, err_in;
   logic          lwle_ff, lwle_in;

   logic              is_digit, is_letter, is_space, is_semi, is_dot;
   logic              c_single, c_head, opf_single, opf_head;
   logic              kw_close, found, close_now, tok_ok, err_next, lw_next, has_tail;
   ctc_pkg::kind_type tok_kind, tail_kind;

   always_comb begin
      is_digit   = (character >= "0") && (character <= "9");
      is_letter  = ((character >= "A") && (character <= "Z")) ||
                   ((character >= "a") && (character <= "z"));
      is_space   = (character == " ") || ((character >= 8'd9) && (character <= 8'd13));
      is_semi    = (character == ";");
      is_dot     = (character == ".");
      c_single   = (character == "+") || (character == "-") || (character == "*") ||
                   (character == "/") || (character == "=") || (character == ">") ||
                   (character == "<");
      c_head     = (character == "=") || (character == "!") || (character == ">") ||
                   (character == "<");
      opf_single = (opf_ff == "+") || (opf_ff == "-") || (opf_ff == "*") ||
                   (opf_ff == "/") || (opf_ff == "=") || (opf_ff == ">") ||
                   (opf_ff == "<");
      opf_head   = (opf_ff == "=") || (opf_ff == "!") || (opf_ff == ">") ||
                   (opf_ff == "<");

      // reserved-word hit on close: candidate alive and length reached
      kw_close = 1'b0;
      for (int k = 0; k < KC; k++) begin
         if (k < ctc_pkg::WORD_COUNT) begin
            if (cand_ff[k] &&
                ctc_pkg::WORD_LEN[k % ctc_pkg::WORD_COUNT] == pos_ff) begin
               kw_close = 1'b1;
            end
         end
      end

      found    = 1'b1;
      tok_kind = ctc_pkg::KIND_VARIABLE;
      if (kw_close) begin
         tok_kind = ctc_pkg::KIND_RESERVED;
      end else if (pos_ff == 4'd1 && opf_single) begin
         tok_kind = ctc_pkg::KIND_OPERATOR;
      end else if (pos_ff == 4'd2 && opf_ff != 8'h00) begin
         tok_kind = ctc_pkg::KIND_OPERATOR;
      end else if (num_ff && dot_ff == 2'd0) begin
         tok_kind = ctc_pkg::KIND_INTEGER;
      end else if (num_ff && dot_ff == 2'd1) begin
         tok_kind = ctc_pkg::KIND_FLOAT;
      end else if (!ident_ff) begin
         found = 1'b0;
      end

      close_now = open_ff && (end_of_text || is_semi || is_space);
      tok_ok    = close_now && found;
      err_next  = err_ff || (close_now && !found);
      lw_next   = close_now ? 1'b0 : lwle_ff;
      has_tail  = end_of_text || is_semi;
      if (end_of_text) begin
         tail_kind = (err_next || !lw_next) ? ctc_pkg::KIND_ST_ERROR : ctc_pkg::KIND_ST_OK;
      end else begin
         tail_kind = ctc_pkg::KIND_LINE_END;
      end

      push.num       = (accept && tok_ok && has_tail) ? 2'd2 :
                       (accept && (tok_ok || has_tail)) ? 2'd1 : 2'd0;
      push.res0.kind = tok_ok ? tok_kind : tail_kind;
      push.res0.last = !(tok_ok && has_tail);
      push.res1.kind = tail_kind;
      push.res1.last = 1'b1;

      open_in  = open_ff;
      pos_in   = pos_ff;
      cand_in  = cand_ff;
      opf_in   = opf_ff;
      num_in   = num_ff;
      dot_in   = dot_ff;
      ident_in = ident_ff;
      err_in   = err_ff;
      lwle_in  = lwle_ff;

      if (accept) begin
         if (end_of_text || is_semi || is_space) begin
            if (close_now) begin
               open_in  = 1'b0;
               pos_in   = 4'd0;
               cand_in  = '1;
               opf_in   = 8'h00;
               num_in   = 1'b1;
               dot_in   = 2'd0;
               ident_in = 1'b1;
            end
            err_in  = err_next;
            lwle_in = end_of_text ? 1'b0 : (is_semi ? 1'b1 : lw_next);
            if (end_of_text) begin
               err_in = 1'b0;
            end
         end else begin
            for (int k = 0; k < KC; k++) begin
               if (k < ctc_pkg::WORD_COUNT) begin
                  if (!(pos_ff < ctc_pkg::WORD_LEN[k % ctc_pkg::WORD_COUNT] &&
                        ctc_pkg::WORD_TEXT[k % ctc_pkg::WORD_COUNT][pos_ff[2:0]] ==
                        character)) begin
                     cand_in[k] = 1'b0;
                  end
               end else begin
                  cand_in[k] = 1'b0;
               end
            end
            if (pos_ff == 4'd0) begin
               opf_in = (c_single || c_head) ? character : 8'h00;
            end else if (pos_ff == 4'd1 && !(character == "=" && opf_head)) begin
               opf_in = 8'h00;
            end
            if (is_dot) begin
               if (dot_ff != 2'd2) begin
                  dot_in = dot_ff + 2'd1;
               end
            end else if (!is_digit) begin
               num_in = 1'b0;
            end
            if ((pos_ff == 4'd0 && is_digit) ||
                !(is_letter || is_digit || character == "_")) begin
               ident_in = 1'b0;
            end
            open_in = 1'b1;
            if (pos_ff < ctc_pkg::POS_MAX) begin
               pos_in = pos_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         pos_ff   <= 4'd0;
         cand_ff  <= '1;
         opf_ff   <= 8'h00;
         num_ff   <= 1'b1;
         dot_ff   <= 2'd0;
         ident_ff <= 1'b1;
         err_ff   <= 1'b0;
         lwle_ff  <= 1'b0;
      end else begin
         open_ff  <= open_in;
         pos_ff   <= pos_in;
         cand_ff  <= cand_in;
         opf_ff   <= opf_in;
         num_ff   <= num_in;
         dot_ff   <= dot_in;
         ident_ff <= ident_in;
         err_ff   <= err_in;
         lwle_ff  <= lwle_in;
      end
   end

endmodule

FILE: src/ctc_out_queue.sv
module ctc_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  ctc_pkg::push_type push,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ctc_pkg::rsl_type  out_word
);

   logic [2:0]       count_ff, count_in;
   ctc_pkg::rsl_type entry_ff [ctc_pkg::QUEUE_DEPTH];
   ctc_pkg::rsl_type entry_in [ctc_pkg::QUEUE_DEPTH];
   logic             pop;
   logic [2:0]       base;

   // room for two words so any input word can be taken
   assign in_ready  = (count_ff <= 3'(ctc_pkg::QUEUE_DEPTH - 2));
   assign out_valid = (count_ff != 3'd0);
   assign out_word  = entry_ff[0];
   assign pop       = out_valid && out_ready;

   always_comb begin
      base = count_ff - {2'b00, pop};
      for (int i = 0; i < ctc_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < ctc_pkg::QUEUE_DEPTH - 1) begin
            entry_in[i] = entry_ff[(i + 1) % ctc_pkg::QUEUE_DEPTH];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if (push.num != 2'd0 && 3'(i) == base) begin
            entry_in[i] = push.res0;
         end
         if (push.num == 2'd2 && 3'(i) == base + 3'd1) begin
            entry_in[i] = push.res1;
         end
      end
      count_in = base + {1'b0, push.num};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ctc_pkg::QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

FILE: src/ctc_checker.sv
module ctc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_token_kind,
   input logic       rsp_last
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) && $stable(rsp_last))
      else $error("stalled rsp word changed");

   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("queue not empty after reset");

   // status word always ends its input word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == ctc_pkg::KIND_ST_ERROR ||
                    rsp_token_kind == ctc_pkg::KIND_ST_OK) |-> rsp_last)
      else $error("status word without last");

   // line end always ends its input word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == ctc_pkg::KIND_LINE_END |-> rsp_last)
      else $error("line end without last");

   // an idle output side with no input drains to ready
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("not ready with empty output");

endmodule

bind c_subset_token_classifier_core ctc_checker u_ctc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_token_kind (rsp_token_kind),
   .rsp_last       (rsp_last)
);
